/* design/drtb_pkg.sv */
// drtb_pkg: shared types, constants and helpers for the dial retry table.
// Used by drtb_cell, drtb_head and dial_retry_table_backoff; no dependencies.
package drtb_pkg;

    localparam int SLOTS     = 16;
    localparam int TIME_BITS = 48;
    localparam int KEY_W     = 64;
    localparam int BOFF_W    = 16;
    localparam int POS_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);

    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_NEXT   = 3'd2;
    localparam logic [2:0] ACT_REPORT = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_EXISTED = 2'd1;
    localparam logic [1:0] ST_ADDED   = 2'd2;

    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_MAX  = 1'b1;

    typedef struct packed {
        logic [2:0]       action;
        logic [KEY_W-1:0] host_key;
        logic             persistent;
        logic             success;
        logic [47:0]      now;
        logic [15:0]      connected_mask;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] chosen_key;
        logic [3:0]       chosen_slot;
        logic [4:0]       entry_count;
        logic             listed;
    } out_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic                 used;
        logic                 pers;
        logic [TIME_BITS-1:0] next_time;
        logic [BOFF_W-1:0]    backoff;
    } entry_t;

    typedef struct packed {
        logic             find;
        logic             apply;
        logic [POS_W-1:0] pos;
    } scan_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_APPLY,
        S_FLUSH
    } state_t;

    // saturating time sum
    function automatic logic [TIME_BITS-1:0] time_add(
        input logic [TIME_BITS-1:0] t,
        input logic [BOFF_W-1:0]    d
    );
        logic [TIME_BITS:0] s;
        s = {1'b0, t} + (TIME_BITS + 1)'(d);
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

endpackage

/* design/dial_retry_table_backoff.sv */
// dial_retry_table_backoff: dial target table with capped exponential backoff.
// Depends on drtb_pkg, drtb_cell and drtb_head.
//
// Usage:
//   in_valid/in_stall/in_item carry one action (add, remove, next, report,
//   clear). out_valid/out_stall/out_item return exactly one result per item.
//   cfg_we/cfg_addr/cfg_wdata write base (0) and max (1) backoff seconds;
//   write only while the block is idle.
// Operation:
//   The table lives in a ring of SLOTS cells that rotates once per pass.
//   Each item takes two passes: a lookup pass (match and first free slot)
//   and an update pass (modify entries, count, listed). The result is
//   registered after the update pass; a new item is taken only once
//   the result has been loaded into the output register.
// Reset:
//   All slots become unused; base is 30 and max is 3600.
// Stall:
//   The result register holds its item while out_stall is high; a finished
//   scan waits until the register is free, and in_stall stays high meanwhile.
module dial_retry_table_backoff (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  drtb_pkg::in_item_t          in_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output drtb_pkg::out_item_t         out_item,
    input  logic                        cfg_we,
    input  logic                        cfg_addr,
    input  logic [drtb_pkg::BOFF_W-1:0] cfg_wdata
);

    drtb_pkg::state_t              state_reg, state_next;
    logic [drtb_pkg::POS_W-1:0]    pos_reg, pos_next;
    drtb_pkg::in_item_t            item_reg;
    logic [drtb_pkg::BOFF_W-1:0]   base_reg;
    logic [drtb_pkg::BOFF_W-1:0]   max_reg;
    logic                          out_valid_reg, out_valid_next;
    drtb_pkg::out_item_t           out_item_reg;
    drtb_pkg::out_item_t           result;
    drtb_pkg::scan_ctrl_t          ctrl;
    drtb_pkg::entry_t              ring_q [drtb_pkg::SLOTS];
    drtb_pkg::entry_t              head_out;
    logic                          in_acc;
    logic                          load_out;
    logic                          shift;
    logic                          last_pos;

    assign in_acc   = in_valid && !in_stall;
    assign shift    = (state_reg == drtb_pkg::S_FIND) || (state_reg == drtb_pkg::S_APPLY);
    assign last_pos = (pos_reg == drtb_pkg::POS_W'(drtb_pkg::SLOTS - 1));

    assign ctrl.find  = (state_reg == drtb_pkg::S_FIND);
    assign ctrl.apply = (state_reg == drtb_pkg::S_APPLY);
    assign ctrl.pos   = pos_reg;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        in_stall       = 1'b1;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            drtb_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                pos_next = '0;
                if (in_valid)
                begin
                    state_next = drtb_pkg::S_FIND;
                end
            end
            drtb_pkg::S_FIND:
            begin
                pos_next = last_pos ? '0 : pos_reg + 1'b1;
                if (last_pos)
                begin
                    state_next = drtb_pkg::S_APPLY;
                end
            end
            drtb_pkg::S_APPLY:
            begin
                pos_next = last_pos ? '0 : pos_reg + 1'b1;
                if (last_pos)
                begin
                    state_next = drtb_pkg::S_FLUSH;
                end
            end
            drtb_pkg::S_FLUSH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = drtb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = drtb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= drtb_pkg::S_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            base_reg      <= 16'd30;
            max_reg       <= 16'd3600;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_addr == drtb_pkg::CFG_BASE))
            begin
                base_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_addr == drtb_pkg::CFG_MAX))
            begin
                max_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            item_reg <= in_item;
        end
        if (load_out)
        begin
            out_item_reg <= result;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < drtb_pkg::SLOTS; gi++)
        begin : g_ring
            if (gi == drtb_pkg::SLOTS - 1)
            begin : g_tail
                drtb_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (head_out),
                    .q     (ring_q[gi])
                );
            end
            else
            begin : g_mid
                drtb_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (ring_q[gi+1]),
                    .q     (ring_q[gi])
                );
            end
        end
    endgenerate

    drtb_head u_head (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .item     (item_reg),
        .base     (base_reg),
        .max_boff (max_reg),
        .ent_in   (ring_q[0]),
        .ent_out  (head_out),
        .result   (result)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.entry_count <= 5'(drtb_pkg::SLOTS)))
        else $error("entry count above table size");

    a_key_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.chosen_key != '0)) |-> (out_item.status == drtb_pkg::ST_DONE))
        else $error("chosen key without done status");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == drtb_pkg::S_FIND) && (pos_reg == '0))
        else $error("accepted item did not start a lookup pass");
`endif

endmodule

/* design/drtb_cell.sv */
// drtb_cell: one slot of the rotating entry ring.
// Depends on drtb_pkg (entry_t).
module drtb_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  drtb_pkg::entry_t d,
    output drtb_pkg::entry_t q
);

    logic                         used_reg;
    logic [drtb_pkg::KEY_W-1:0]     key_reg;
    logic                         pers_reg;
    logic [drtb_pkg::TIME_BITS-1:0] time_reg;
    logic [drtb_pkg::BOFF_W-1:0]    boff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (shift)
        begin
            used_reg <= d.used;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg  <= d.key;
            pers_reg <= d.pers;
            time_reg <= d.next_time;
            boff_reg <= d.backoff;
        end
    end

    assign q = '{key: key_reg, used: used_reg, pers: pers_reg,
                 next_time: time_reg, backoff: boff_reg};

endmodule

/* design/drtb_head.sv */
// drtb_head: processing cell at the end of the ring; looks up, updates and
// accumulates per item. Depends on drtb_pkg.
module drtb_head (
    input  logic                        clk,
    input  logic                        rst_n,
    input  drtb_pkg::scan_ctrl_t        ctrl,
    input  drtb_pkg::in_item_t          item,
    input  logic [drtb_pkg::BOFF_W-1:0] base,
    input  logic [drtb_pkg::BOFF_W-1:0] max_boff,
    input  drtb_pkg::entry_t            ent_in,
    output drtb_pkg::entry_t            ent_out,
    output drtb_pkg::out_item_t         result
);

    logic                         found_reg, found_next;
    logic [drtb_pkg::POS_W-1:0]   fidx_reg, fidx_next;
    logic                         free_reg, free_next;
    logic [drtb_pkg::POS_W-1:0]   free_idx_reg, free_idx_next;
    logic                         done_reg, done_next;
    logic [drtb_pkg::KEY_W-1:0]   ckey_reg, ckey_next;
    logic [drtb_pkg::POS_W-1:0]   cslot_reg, cslot_next;
    logic [drtb_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                         listed_reg, listed_next;

    logic                         first;
    logic                         hit;
    logic                         take;
    logic                         due;
    logic                         conn_bit;
    logic [6:0]                   pos_wide;
    logic [drtb_pkg::BOFF_W-1:0]  delta;
    logic [drtb_pkg::TIME_BITS-1:0] sum;
    logic [drtb_pkg::BOFF_W:0]    dbl;
    logic                         done_prev;
    logic [drtb_pkg::CNT_W-1:0]   count_prev;
    logic                         listed_prev;
    drtb_pkg::entry_t             e_n;

    assign first    = (ctrl.pos == '0);
    assign hit      = found_reg && (ctrl.pos == fidx_reg);
    assign pos_wide = 7'(ctrl.pos);
    assign conn_bit = (pos_wide < 7'd16) && item.connected_mask[pos_wide[3:0]];
    assign due      = ent_in.used && (ent_in.next_time <= item.now);
    assign dbl      = {ent_in.backoff, 1'b0};

    // one adder serves next and report
    always_comb
    begin
        if (item.action == drtb_pkg::ACT_NEXT)
        begin
            delta = conn_bit ? base : ent_in.backoff;
        end
        else
        begin
            delta = item.success ? base : ent_in.backoff;
        end
    end

    assign sum = drtb_pkg::time_add(item.now, delta);

    always_comb
    begin
        done_prev   = first ? 1'b0 : done_reg;
        count_prev  = first ? '0 : count_reg;
        listed_prev = first ? 1'b0 : listed_reg;
        e_n         = ent_in;
        take        = 1'b0;

        if (ctrl.apply)
        begin
            unique case (item.action)
                drtb_pkg::ACT_ADD:
                begin
                    if (item.host_key != '0)
                    begin
                        if (found_reg)
                        begin
                            if (hit && item.persistent)
                            begin
                                e_n.pers = 1'b1;
                            end
                        end
                        else if (free_reg && (ctrl.pos == free_idx_reg))
                        begin
                            e_n.key       = item.host_key;
                            e_n.used      = 1'b1;
                            e_n.pers      = item.persistent;
                            e_n.next_time = item.now;
                            e_n.backoff   = base;
                        end
                    end
                end
                drtb_pkg::ACT_REMOVE:
                begin
                    if (hit)
                    begin
                        e_n.used = 1'b0;
                    end
                end
                drtb_pkg::ACT_NEXT:
                begin
                    if (!done_prev && due)
                    begin
                        if (conn_bit)
                        begin
                            e_n.next_time = sum;
                        end
                        else
                        begin
                            take = 1'b1;
                            if (!ent_in.pers)
                            begin
                                e_n.used = 1'b0;
                            end
                            else
                            begin
                                e_n.next_time = sum;
                            end
                        end
                    end
                end
                drtb_pkg::ACT_REPORT:
                begin
                    if (hit)
                    begin
                        e_n.next_time = sum;
                        if (item.success)
                        begin
                            e_n.backoff = base;
                        end
                        else if (dbl > {1'b0, max_boff})
                        begin
                            e_n.backoff = max_boff;
                        end
                        else
                        begin
                            e_n.backoff = dbl[drtb_pkg::BOFF_W-1:0];
                        end
                    end
                end
                drtb_pkg::ACT_CLEAR:
                begin
                    e_n.used = 1'b0;
                end
                default:
                begin
                    e_n = ent_in;
                end
            endcase
        end

        found_next    = found_reg;
        fidx_next     = fidx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        if (ctrl.find)
        begin
            found_next = first ? 1'b0 : found_reg;
            free_next  = first ? 1'b0 : free_reg;
            if (!found_next && ent_in.used && (ent_in.key == item.host_key))
            begin
                found_next = 1'b1;
                fidx_next  = ctrl.pos;
            end
            if (!free_next && !ent_in.used)
            begin
                free_next     = 1'b1;
                free_idx_next = ctrl.pos;
            end
        end

        done_next   = done_reg;
        ckey_next   = ckey_reg;
        cslot_next  = cslot_reg;
        count_next  = count_reg;
        listed_next = listed_reg;
        if (ctrl.apply)
        begin
            done_next   = done_prev | take;
            if (take)
            begin
                ckey_next  = ent_in.key;
                cslot_next = ctrl.pos;
            end
            count_next  = count_prev + drtb_pkg::CNT_W'(e_n.used);
            listed_next = listed_prev
                        | (e_n.used && e_n.pers && (e_n.key == item.host_key));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg  <= 1'b0;
            free_reg   <= 1'b0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            listed_reg <= 1'b0;
        end
        else
        begin
            found_reg  <= found_next;
            free_reg   <= free_next;
            done_reg   <= done_next;
            count_reg  <= count_next;
            listed_reg <= listed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fidx_reg     <= fidx_next;
        free_idx_reg <= free_idx_next;
        ckey_reg     <= ckey_next;
        cslot_reg    <= cslot_next;
    end

    assign ent_out = e_n;

    always_comb
    begin
        result             = '0;
        result.entry_count = 5'(count_reg);
        result.listed      = listed_reg;
        unique case (item.action)
            drtb_pkg::ACT_ADD:
            begin
                if (item.host_key != '0)
                begin
                    if (found_reg)
                    begin
                        result.status      = drtb_pkg::ST_EXISTED;
                        result.chosen_slot = 4'(fidx_reg);
                    end
                    else if (free_reg)
                    begin
                        result.status      = drtb_pkg::ST_ADDED;
                        result.chosen_slot = 4'(free_idx_reg);
                    end
                end
            end
            drtb_pkg::ACT_REMOVE, drtb_pkg::ACT_REPORT:
            begin
                if (found_reg)
                begin
                    result.status      = drtb_pkg::ST_DONE;
                    result.chosen_slot = 4'(fidx_reg);
                end
            end
            drtb_pkg::ACT_NEXT:
            begin
                if (done_reg)
                begin
                    result.status      = drtb_pkg::ST_DONE;
                    result.chosen_key  = ckey_reg;
                    result.chosen_slot = 4'(cslot_reg);
                end
            end
            drtb_pkg::ACT_CLEAR:
            begin
                result.status = drtb_pkg::ST_DONE;
            end
            default:
            begin
                result.status = drtb_pkg::ST_NONE;
            end
        endcase
    end

endmodule

/* tb/dial_retry_table_backoff_test.sv */
// dial_retry_table_backoff_test: self-checking bench for the dial retry table.
// Depends on drtb_pkg and dial_retry_table_backoff; drives items, predicts
// results with its own table model and compares every field.
module dial_retry_table_backoff_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE = 80;

    typedef struct packed {
        logic [2:0]          act;
        logic [63:0]         key;
        logic                pers;
        logic                ok;
        logic [47:0]         t;
        logic [15:0]         conn;
        logic                known;
        drtb_pkg::out_item_t res;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    drtb_pkg::in_item_t in_item;
    logic out_valid;
    logic out_stall;
    drtb_pkg::out_item_t out_item;
    logic cfg_we;
    logic cfg_addr;
    logic [15:0] cfg_wdata;

    // predictor state
    logic [63:0] tbl_key [drtb_pkg::SLOTS];
    logic        tbl_used [drtb_pkg::SLOTS];
    logic        tbl_pers [drtb_pkg::SLOTS];
    logic [47:0] tbl_next [drtb_pkg::SLOTS];
    logic [15:0] tbl_boff [drtb_pkg::SLOTS];
    logic [15:0] base_sec;
    logic [15:0] max_sec;

    drtb_pkg::out_item_t pending_results[$];
    int        errors;
    int        cycles;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_off;
    int        n_checked;
    int        n_chosen;
    logic [63:0] key_pool [8];
    logic [47:0] clock_now;

    dial_retry_table_backoff u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [47:0] sat_add(logic [47:0] a, logic [15:0] d);
        logic [48:0] s;
        s = {1'b0, a} + {33'd0, d};
        return s[48] ? {48{1'b1}} : s[47:0];
    endfunction

    function automatic int find_slot(logic [63:0] k);
        for (int i = 0; i < drtb_pkg::SLOTS; i++)
            if (tbl_used[i] && tbl_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic drtb_pkg::out_item_t predict_dial(drtb_pkg::in_item_t it);
        drtb_pkg::out_item_t r;
        int f;
        int i;
        logic [16:0] dbl;
        r = '0;
        case (it.action)
            drtb_pkg::ACT_ADD:
            begin
                if (it.host_key != 0)
                begin
                    f = find_slot(it.host_key);
                    if (f >= 0)
                    begin
                        if (it.persistent)
                            tbl_pers[f] = 1'b1;
                        r.status = drtb_pkg::ST_EXISTED;
                        r.chosen_slot = f[3:0];
                    end
                    else
                    begin
                        for (i = 0; i < drtb_pkg::SLOTS; i++)
                            if (!tbl_used[i])
                                break;
                        if (i < drtb_pkg::SLOTS)
                        begin
                            tbl_key[i] = it.host_key;
                            tbl_used[i] = 1'b1;
                            tbl_pers[i] = it.persistent;
                            tbl_next[i] = it.now;
                            tbl_boff[i] = base_sec;
                            r.status = drtb_pkg::ST_ADDED;
                            r.chosen_slot = i[3:0];
                        end
                    end
                end
            end
            drtb_pkg::ACT_REMOVE:
            begin
                f = find_slot(it.host_key);
                if (f >= 0)
                begin
                    tbl_used[f] = 1'b0;
                    r.status = drtb_pkg::ST_DONE;
                    r.chosen_slot = f[3:0];
                end
            end
            drtb_pkg::ACT_NEXT:
            begin
                for (i = 0; i < drtb_pkg::SLOTS; i++)
                begin
                    if (!tbl_used[i] || tbl_next[i] > it.now)
                        continue;
                    if (it.connected_mask[i])
                    begin
                        tbl_next[i] = sat_add(it.now, base_sec);
                        continue;
                    end
                    if (!tbl_pers[i])
                        tbl_used[i] = 1'b0;
                    else
                        tbl_next[i] = sat_add(it.now, tbl_boff[i]);
                    r.status = drtb_pkg::ST_DONE;
                    r.chosen_key = tbl_key[i];
                    r.chosen_slot = i[3:0];
                    break;
                end
            end
            drtb_pkg::ACT_REPORT:
            begin
                f = find_slot(it.host_key);
                if (f >= 0)
                begin
                    if (it.success)
                    begin
                        tbl_boff[f] = base_sec;
                        tbl_next[f] = sat_add(it.now, base_sec);
                    end
                    else
                    begin
                        dbl = {tbl_boff[f], 1'b0};
                        tbl_next[f] = sat_add(it.now, tbl_boff[f]);
                        tbl_boff[f] = (dbl > {1'b0, max_sec}) ? max_sec : dbl[15:0];
                    end
                    r.status = drtb_pkg::ST_DONE;
                    r.chosen_slot = f[3:0];
                end
            end
            drtb_pkg::ACT_CLEAR:
            begin
                for (i = 0; i < drtb_pkg::SLOTS; i++)
                begin
                    tbl_key[i] = '0;
                    tbl_used[i] = 1'b0;
                    tbl_pers[i] = 1'b0;
                    tbl_next[i] = '0;
                    tbl_boff[i] = '0;
                end
                r.status = drtb_pkg::ST_DONE;
            end
            default: ;
        endcase
        for (i = 0; i < drtb_pkg::SLOTS; i++)
            if (tbl_used[i])
                r.entry_count = r.entry_count + 5'd1;
        f = find_slot(it.host_key);
        r.listed = (f >= 0) ? tbl_pers[f] : 1'b0;
        return r;
    endfunction

    // valid drops only while the sender idles, so each step sees one update
    task automatic send_item(drtb_pkg::in_item_t it, bit known, drtb_pkg::out_item_t res);
        drtb_pkg::out_item_t p;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        p = predict_dial(it);
        if (known && p != res)
        begin
            $error("directed row disagrees with predictor: exp %h got %h", res, p);
            errors++;
        end
        pending_results.push_back(p);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == drtb_pkg::CFG_BASE)
            base_sec = val;
        else
            max_sec = val;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic drtb_pkg::in_item_t rand_dial_item();
        drtb_pkg::in_item_t it;
        int sel;
        it.action = ($urandom_range(99) < 3) ? 3'($urandom_range(7)) :
                    (($urandom_range(99) < 2) ? drtb_pkg::ACT_CLEAR :
                     3'($urandom_range(3)));
        sel = $urandom_range(99);
        if (sel < 80)
            it.host_key = key_pool[$urandom_range(7)];
        else if (sel < 85)
            it.host_key = '0;
        else
            it.host_key = {$urandom, $urandom};
        it.persistent = 1'($urandom_range(1));
        it.success = 1'($urandom_range(1));
        sel = $urandom_range(99);
        if (sel < 3)
            clock_now = 48'({$urandom, $urandom});
        else if (sel < 6)
            clock_now = {48{1'b1}} - 48'($urandom_range(200));
        else
            clock_now = clock_now + 48'($urandom_range(400));
        it.now = clock_now;
        it.connected_mask = ($urandom_range(1)) ? 16'($urandom) : 16'h0;
        return it;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        drtb_pkg::out_item_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result %h", out_item);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (exp_r.chosen_key != 0)
                    n_chosen++;
                if (out_item.status !== exp_r.status)
                begin
                    $error("status exp %0d got %0d", exp_r.status, out_item.status);
                    errors++;
                end
                if (out_item.chosen_key !== exp_r.chosen_key)
                begin
                    $error("chosen_key exp %h got %h", exp_r.chosen_key, out_item.chosen_key);
                    errors++;
                end
                if (out_item.chosen_slot !== exp_r.chosen_slot)
                begin
                    $error("chosen_slot exp %0d got %0d", exp_r.chosen_slot,
                           out_item.chosen_slot);
                    errors++;
                end
                if (out_item.entry_count !== exp_r.entry_count)
                begin
                    $error("entry_count exp %0d got %0d", exp_r.entry_count,
                           out_item.entry_count);
                    errors++;
                end
                if (out_item.listed !== exp_r.listed)
                begin
                    $error("listed exp %0d got %0d", exp_r.listed, out_item.listed);
                    errors++;
                end
            end
        end
    end

    // receiver stall, with an optional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        dir_row_t rows[$];
        drtb_pkg::out_item_t r;
        drtb_pkg::in_item_t it;
        int phase_items;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_addr = drtb_pkg::CFG_BASE;
        cfg_wdata = '0;
        hold_off = 1'b0;
        errors = 0;
        cycles = 0;
        n_checked = 0;
        n_chosen = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        clock_now = 48'd1000;
        base_sec = 16'd30;
        max_sec = 16'd3600;
        for (int i = 0; i < drtb_pkg::SLOTS; i++)
        begin
            tbl_key[i] = '0;
            tbl_used[i] = 1'b0;
            tbl_pers[i] = 1'b0;
            tbl_next[i] = '0;
            tbl_boff[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: act, key, pers, ok, now, conn, known, {status,key,slot,count,listed}
        r = '0;
        rows.push_back({drtb_pkg::ACT_NEXT, 64'd0, 1'b0, 1'b0, 48'd0, 16'h0, 1'b1, r});
        r = '0;
        rows.push_back({drtb_pkg::ACT_ADD, 64'd0, 1'b1, 1'b0, 48'd5, 16'h0, 1'b1, r});
        r = '0; r.status = drtb_pkg::ST_ADDED; r.entry_count = 5'd1; r.listed = 1'b1;
        rows.push_back({drtb_pkg::ACT_ADD, {64{1'b1}}, 1'b1, 1'b0, 48'd10, 16'h0, 1'b1, r});
        r = '0; r.status = drtb_pkg::ST_ADDED; r.chosen_slot = 4'd1; r.entry_count = 5'd2;
        rows.push_back({drtb_pkg::ACT_ADD, 64'd7, 1'b0, 1'b0, 48'd10, 16'h0, 1'b1, r});
        rows.push_back({drtb_pkg::ACT_ADD, 64'd7, 1'b1, 1'b0, 48'd10, 16'h0, 1'b0, r});
        rows.push_back({drtb_pkg::ACT_ADD, 64'd7, 1'b0, 1'b0, 48'd10, 16'h0, 1'b0, r});
        rows.push_back({drtb_pkg::ACT_NEXT, 64'd0, 1'b0, 1'b0, 48'd10, 16'h0001, 1'b0, r});
        rows.push_back({drtb_pkg::ACT_NEXT, 64'd0, 1'b0, 1'b0, {48{1'b1}}, 16'hffff,
                        1'b0, r});
        rows.push_back({drtb_pkg::ACT_REPORT, 64'd7, 1'b0, 1'b0, {48{1'b1}}, 16'h0,
                        1'b0, r});
        rows.push_back({drtb_pkg::ACT_REPORT, 64'd7, 1'b0, 1'b1, 48'd50, 16'h0, 1'b0, r});
        rows.push_back({drtb_pkg::ACT_REPORT, 64'd99, 1'b0, 1'b0, 48'd50, 16'h0, 1'b0, r});
        rows.push_back({drtb_pkg::ACT_REMOVE, 64'd99, 1'b0, 1'b0, 48'd50, 16'h0, 1'b0, r});
        rows.push_back({drtb_pkg::ACT_REMOVE, 64'd0, 1'b0, 1'b0, 48'd50, 16'h0, 1'b0, r});
        rows.push_back({3'd5, 64'd7, 1'b1, 1'b1, 48'd50, 16'h0, 1'b0, r});
        rows.push_back({3'd7, {64{1'b1}}, 1'b1, 1'b1, {48{1'b1}}, 16'hffff, 1'b0, r});
        for (int i = 0; i < 16; i++)
            rows.push_back({drtb_pkg::ACT_ADD, 64'(100 + i), 1'(i[0]), 1'b0, 48'd60, 16'h0,
                            1'b0, r});
        rows.push_back({drtb_pkg::ACT_NEXT, 64'd0, 1'b0, 1'b0, 48'd100, 16'haaaa, 1'b0, r});
        rows.push_back({drtb_pkg::ACT_REMOVE, {64{1'b1}}, 1'b0, 1'b0, 48'd0, 16'h0,
                        1'b0, r});
        r = '0; r.status = drtb_pkg::ST_DONE;
        rows.push_back({drtb_pkg::ACT_CLEAR, 64'd0, 1'b0, 1'b0, 48'd0, 16'h0, 1'b1, r});
        foreach (rows[i])
        begin
            it.action = rows[i].act;
            it.host_key = rows[i].key;
            it.persistent = rows[i].pers;
            it.success = rows[i].ok;
            it.now = rows[i].t;
            it.connected_mask = rows[i].conn;
            send_item(it, rows[i].known, rows[i].res);
        end
        drain();

        // random phases across register settings and idle patterns
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(drtb_pkg::CFG_BASE, 16'd1);
                    write_reg(drtb_pkg::CFG_MAX, 16'hffff);
                end
                1:
                begin
                    write_reg(drtb_pkg::CFG_BASE, 16'hffff);
                    write_reg(drtb_pkg::CFG_MAX, 16'd1);
                end
                2:
                begin
                    write_reg(drtb_pkg::CFG_BASE, 16'd0);
                    write_reg(drtb_pkg::CFG_MAX, 16'd40);
                end
                3:
                begin
                    write_reg(drtb_pkg::CFG_BASE, 16'd7);
                    write_reg(drtb_pkg::CFG_MAX, 16'd300);
                end
                4:
                begin
                    write_reg(drtb_pkg::CFG_BASE, 16'($urandom));
                    write_reg(drtb_pkg::CFG_MAX, 16'($urandom));
                end
                default:
                begin
                    write_reg(drtb_pkg::CFG_BASE, 16'd30);
                    write_reg(drtb_pkg::CFG_MAX, 16'd3600);
                end
            endcase
            send_idle_pct = (ph < 2) ? 13 : ((ph < 4) ? 80 : 0);
            recv_idle_pct = (ph < 2) ? 80 : ((ph < 4) ? 13 : 0);
            for (int k = 0; k < 8; k++)
                key_pool[k] = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'(k + 1);
            phase_items = 190;
            if (ph == 5)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (600) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            for (int n = 0; n < phase_items; n++)
                send_item(rand_dial_item(), 1'b0, r);
            drain();
        end

        $display("checked %0d results, %0d of them dialing a target", n_checked, n_chosen);
        $display("covered all actions, full table, saturation and six register settings");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
